// ===== rtl/console_line_assembler_macros.svh =====
// ----------------------------------------------------------------------------
// console line assembler assertion macros
// concurrent assertion shorthands clocked on clk_i, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_ASSEMBLER_MACROS_SVH
`define CONSOLE_LINE_ASSEMBLER_MACROS_SVH

// same-cycle implication
`define CLA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cla_pkg.sv =====
// ----------------------------------------------------------------------------
// cla_pkg
// types, codes and constants shared by the console line assembler
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int unsigned LINE_BYTES_DEF = 64;

  localparam logic [5:0]  MAX_LEN_RESET = 6'd63;
  localparam logic [15:0] SAT16         = 16'hFFFF;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    KIND_ECHO     = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_TOO_LONG = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       byte_valid;
    logic       hw_overrun;
  } in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  result_byte;
    logic        last_of_run;
    logic [15:0] overrun_total;
    logic [15:0] overflow_total;
  } out_t;

  typedef struct packed {
    logic [5:0] max_line_length;
  } cfg_t;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_PRINT,
    CLS_ERASE,
    CLS_LINE_END
  } in_class_e;

  typedef enum logic [2:0] {
    SEL_RX,
    SEL_LF,
    SEL_BS,
    SEL_SPACE,
    SEL_LINE,
    SEL_TOO_LONG,
    SEL_EMPTY
  } emit_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ECHO,
    ST_BS1,
    ST_BS2,
    ST_BS3,
    ST_NEWLINE,
    ST_EVENT,
    ST_RUN
  } ctl_state_e;

  typedef struct packed {
    logic      load_in;
    logic      commit;
    logic      emit;
    emit_sel_e sel;
    logic      last;
    logic      rd_clear;
    logic      rd_next;
    logic      line_done;
  } cla_cmd_t;

  typedef struct packed {
    in_class_e cls;
    logic      overflow;
    logic      length_zero;
    logic      run_last;
    logic      out_free;
  } cla_sts_t;

endpackage

// ===== rtl/cla_stream_if.sv =====
// ----------------------------------------------------------------------------
// cla_stream_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface cla_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/cla_ctrl.sv =====
// ----------------------------------------------------------------------------
// cla_ctrl
// sequencer: decodes one byte and steps through the results it causes
// ----------------------------------------------------------------------------
`include "console_line_assembler_macros.svh"

module cla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cla_pkg::cla_sts_t sts_i,
  output cla_pkg::cla_cmd_t cmd_o
);
  import cla_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = SEL_RX;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.commit = 1'b1;
        case (sts_i.cls)
          CLS_PRINT:    state_d = ST_ECHO;
          CLS_ERASE:    state_d = ST_BS1;
          CLS_LINE_END: state_d = ST_NEWLINE;
          default:      state_d = ST_IDLE;
        endcase
      end
      ST_ECHO: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_RX;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_BS1: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_BS;
          state_d    = ST_BS2;
        end
      end
      ST_BS2: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_SPACE;
          state_d    = ST_BS3;
        end
      end
      ST_BS3: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_BS;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_NEWLINE: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_LF;
          cmd_o.rd_clear = 1'b1;
          state_d = (sts_i.overflow || sts_i.length_zero) ? ST_EVENT : ST_RUN;
        end
      end
      ST_EVENT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = sts_i.overflow ? SEL_TOO_LONG : SEL_EMPTY;
          cmd_o.last      = 1'b1;
          cmd_o.line_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = SEL_LINE;
          cmd_o.last      = sts_i.run_last;
          cmd_o.rd_next   = !sts_i.run_last;
          cmd_o.line_done = sts_i.run_last;
          if (sts_i.run_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `CLA_ASSERT(a_emit_needs_room, cmd_o.emit, sts_i.out_free, "result loaded into a busy output")
  `CLA_ASSERT(a_line_done_last, cmd_o.line_done, cmd_o.emit && cmd_o.last, "line closed off a last result")
  `CLA_ASSERT_NEXT(a_load_then_decode, cmd_o.load_in, state_q == ST_DISPATCH, "accepted byte not decoded")

endmodule

// ===== rtl/cla_dp.sv =====
// ----------------------------------------------------------------------------
// cla_dp
// line state, line store, counters and the output register
// ----------------------------------------------------------------------------
`include "console_line_assembler_macros.svh"

module cla_dp #(
  parameter int unsigned LINE_BYTES = cla_pkg::LINE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cla_pkg::in_t      in_payload_i,
  input  logic              cfg_we_i,
  input  cla_pkg::cfg_t     cfg_data_i,
  input  cla_pkg::cla_cmd_t cmd_i,
  output cla_pkg::cla_sts_t sts_o,
  output logic              out_valid_o,
  output cla_pkg::out_t     out_payload_o,
  input  logic              out_ready_i
);
  import cla_pkg::*;

  localparam int unsigned DEPTH  = LINE_BYTES - 1;
  localparam int unsigned LEN_W  = $clog2(LINE_BYTES);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CMP_W  = (LEN_W > 6) ? LEN_W : 6;
  localparam logic [CMP_W-1:0] MAX_KEEP = CMP_W'(DEPTH);

  logic [7:0]       byte_q;
  logic             valid_q;
  logic [5:0]       max_len_q;
  logic [LEN_W-1:0] length_q, length_d;
  logic             overflow_q, overflow_d;
  logic             last_cr_q, last_cr_d;
  logic [15:0]      overrun_cnt_q, overrun_cnt_d;
  logic [15:0]      overflow_cnt_q, overflow_cnt_d;
  logic [LEN_W-1:0] rd_idx_q, rd_addr;
  logic [7:0]       rd_data_q;
  logic [7:0]       mem [DEPTH];
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             is_eol, is_erase, is_print, lf_swallow, room, store_we;
  logic [CMP_W-1:0] limit;

  // byte decode
  always_comb begin
    is_eol     = (byte_q == CH_CR) || (byte_q == CH_LF);
    lf_swallow = (byte_q == CH_LF) && last_cr_q;
    is_erase   = (byte_q == CH_BS) || (byte_q == CH_DEL);
    is_print   = (byte_q >= CH_SPACE) && (byte_q <= CH_TILDE);
    limit      = (CMP_W'(max_len_q) < MAX_KEEP) ? CMP_W'(max_len_q) : MAX_KEEP;
    room       = CMP_W'(length_q) < limit;
    store_we   = cmd_i.commit && valid_q && is_print && room;
  end

  always_comb begin
    sts_o.cls = CLS_IGNORE;
    if (valid_q) begin
      if (is_eol) begin
        sts_o.cls = lf_swallow ? CLS_IGNORE : CLS_LINE_END;
      end else if (is_erase) begin
        sts_o.cls = (length_q != '0) ? CLS_ERASE : CLS_IGNORE;
      end else if (is_print) begin
        sts_o.cls = CLS_PRINT;
      end
    end
    sts_o.overflow    = overflow_q;
    sts_o.length_zero = (length_q == '0);
    sts_o.run_last    = (rd_idx_q == length_q - LEN_W'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // line state update
  always_comb begin
    length_d       = length_q;
    overflow_d     = overflow_q;
    last_cr_d      = last_cr_q;
    overrun_cnt_d  = overrun_cnt_q;
    overflow_cnt_d = overflow_cnt_q;
    if (cmd_i.load_in && in_payload_i.hw_overrun && (overrun_cnt_q != SAT16)) begin
      overrun_cnt_d = overrun_cnt_q + 16'd1;
    end
    if (cmd_i.commit && valid_q) begin
      if (is_eol) begin
        last_cr_d = !lf_swallow && (byte_q == CH_CR);
        if (!lf_swallow && overflow_q && (overflow_cnt_q != SAT16)) begin
          overflow_cnt_d = overflow_cnt_q + 16'd1;
        end
      end else begin
        last_cr_d = 1'b0;
        if (is_erase && (length_q != '0)) begin
          length_d = length_q - LEN_W'(1);
        end else if (is_print) begin
          if (room) begin
            length_d = length_q + LEN_W'(1);
          end else begin
            overflow_d = 1'b1;
          end
        end
      end
    end
    if (cmd_i.line_done) begin
      length_d   = '0;
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q      <= MAX_LEN_RESET;
      length_q       <= '0;
      overflow_q     <= 1'b0;
      last_cr_q      <= 1'b0;
      overrun_cnt_q  <= '0;
      overflow_cnt_q <= '0;
      rd_idx_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i.max_line_length;
      end
      length_q       <= length_d;
      overflow_q     <= overflow_d;
      last_cr_q      <= last_cr_d;
      overrun_cnt_q  <= overrun_cnt_d;
      overflow_cnt_q <= overflow_cnt_d;
      rd_idx_q       <= rd_addr;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q  <= in_payload_i.rx_byte;
      valid_q <= in_payload_i.byte_valid;
    end
    out_q <= out_d;
  end

  // line store, read data always tracks rd_idx_q
  always_comb begin
    rd_addr = rd_idx_q;
    if (cmd_i.rd_clear) begin
      rd_addr = '0;
    end else if (cmd_i.rd_next) begin
      rd_addr = rd_idx_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem[length_q[ADDR_W-1:0]] <= byte_q;
    end
    rd_data_q <= mem[rd_addr[ADDR_W-1:0]];
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit) begin
      out_valid_d          = 1'b1;
      out_d.last_of_run    = cmd_i.last;
      out_d.overrun_total  = overrun_cnt_q;
      out_d.overflow_total = overflow_cnt_q;
      out_d.result_kind    = KIND_ECHO;
      out_d.result_byte    = 8'h00;
      case (cmd_i.sel)
        SEL_RX:       out_d.result_byte = byte_q;
        SEL_LF:       out_d.result_byte = CH_LF;
        SEL_BS:       out_d.result_byte = CH_BS;
        SEL_SPACE:    out_d.result_byte = CH_SPACE;
        SEL_LINE: begin
          out_d.result_kind = KIND_LINE;
          out_d.result_byte = rd_data_q;
        end
        SEL_TOO_LONG: out_d.result_kind = KIND_TOO_LONG;
        SEL_EMPTY:    out_d.result_kind = KIND_EMPTY;
        default:      out_d.result_byte = 8'h00;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

  `CLA_ASSERT(a_length_bound, 1'b1, length_q <= LEN_W'(DEPTH), "line length past store depth")
  `CLA_ASSERT_NEXT(a_ovf_count_mono, 1'b1, overflow_cnt_q >= $past(overflow_cnt_q), "overflow count fell")
  `CLA_ASSERT(a_run_in_line, cmd_i.emit && (cmd_i.sel == SEL_LINE), (length_q != '0) && !overflow_q, "line byte sent without a clean stored line")

endmodule

// ===== rtl/console_line_assembler.sv =====
// ----------------------------------------------------------------------------
// console_line_assembler
// edits received bytes into a command line and reports it at the line end
// ----------------------------------------------------------------------------
// an item is taken in ST_IDLE and decoded in ST_DISPATCH, then its results go
// into the output register one result per cycle while the sink keeps up; a line end
// gives up to min(LINE_BYTES, 64) results, line bytes read from the store port
// one per cycle while the sink keeps up; the next item is taken the cycle after
// the last result. reset is asynchronous: line state and counts clear, the
// limit returns to 63, and the line store keeps its contents with no clearing pass
module console_line_assembler #(
  parameter int unsigned LINE_BYTES = cla_pkg::LINE_BYTES_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  cla_stream_if.sink   in_i,
  cla_stream_if.sink   cfg_i,
  cla_stream_if.source out_o
);
  import cla_pkg::*;

  cla_cmd_t cmd;
  cla_sts_t sts;

  assign cfg_i.ready = 1'b1;

  cla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cla_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_payload_i  (in_i.payload),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.payload),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_payload_o (out_o.payload),
    .out_ready_i   (out_o.ready)
  );

endmodule

// ===== sim/console_line_assembler_test.sv =====
// ----------------------------------------------------------------------------
// console_line_assembler_test
// self-checking bench for the console line assembler: a directed table of
// edits, line ends and limit changes, then random command lines with typing,
// erasing and noise; every result is compared in order with the results of the
// typed table rows or of a line-editing predictor
// ----------------------------------------------------------------------------
module console_line_assembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cla_pkg::*;

  localparam int HOLD_OFF    = 6;
  localparam int STALL_LIMIT = 1000;
  localparam int BLOCK_ITEMS = 10;
  localparam int DIR_ROWS    = 27;

  typedef struct {
    bit          wr_cfg;
    logic [7:0]  data;
    logic        vld;
    logic        ovr;
    bit          typed;
    int          n;
    kind_e       k0;
    logic [7:0]  b0;
    kind_e       k1;
    logic [7:0]  b1;
    kind_e       k2;
    logic [7:0]  b2;
    logic [15:0] ovr_t;
    logic [15:0] ovf_t;
  } step_row_t;

  // typed rows carry their results; the others go through the predictor
  step_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, CH_CR, 1'b1, 1'b0, 1'b1, 2, KIND_ECHO, CH_LF, KIND_EMPTY, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, CH_LF, 1'b1, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, CH_LF, 1'b1, 1'b0, 1'b1, 2, KIND_ECHO, CH_LF, KIND_EMPTY, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, CH_BS, 1'b1, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, CH_SPACE, 1'b1, 1'b0, 1'b1, 1, KIND_ECHO, CH_SPACE, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, CH_TILDE, 1'b1, 1'b0, 1'b1, 1, KIND_ECHO, CH_TILDE, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, 8'h1F, 1'b1, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd1, 16'd0},
    '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd2, 16'd0},
    '{1'b0, 8'h80, 1'b1, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd2, 16'd0},
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd2, 16'd0},
    '{1'b0, CH_DEL, 1'b1, 1'b0, 1'b1, 3, KIND_ECHO, CH_BS, KIND_ECHO, CH_SPACE,
      KIND_ECHO, CH_BS, 16'd2, 16'd0},
    '{1'b0, CH_CR, 1'b1, 1'b0, 1'b1, 2, KIND_ECHO, CH_LF, KIND_LINE, CH_SPACE,
      KIND_ECHO, 8'h00, 16'd2, 16'd0},
    '{1'b0, CH_LF, 1'b1, 1'b0, 1'b1, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd2, 16'd0},
    '{1'b0, CH_CR, 1'b1, 1'b0, 1'b1, 2, KIND_ECHO, CH_LF, KIND_EMPTY, 8'h00,
      KIND_ECHO, 8'h00, 16'd2, 16'd0},
    '{1'b0, 8'h41, 1'b1, 1'b1, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, CH_LF, 1'b1, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b1, 8'd1, 1'b0, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, 8'h61, 1'b1, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, 8'h62, 1'b1, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, CH_BS, 1'b1, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, CH_CR, 1'b1, 1'b0, 1'b1, 2, KIND_ECHO, CH_LF, KIND_TOO_LONG, 8'h00,
      KIND_ECHO, 8'h00, 16'd3, 16'd1},
    '{1'b1, 8'd0, 1'b0, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, 8'h7A, 1'b1, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b0, CH_LF, 1'b1, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0},
    '{1'b1, 8'd63, 1'b0, 1'b0, 1'b0, 0, KIND_ECHO, 8'h00, KIND_ECHO, 8'h00,
      KIND_ECHO, 8'h00, 16'd0, 16'd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cla_stream_if #(.payload_t(in_t))  rx_ch ();
  cla_stream_if #(.payload_t(cfg_t)) cfg_ch ();
  cla_stream_if #(.payload_t(out_t)) res_ch ();

  console_line_assembler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rx_ch),
    .cfg_i  (cfg_ch),
    .out_o  (res_ch)
  );

  // line editing state of the predictor
  logic [7:0]  line_mem [LINE_BYTES_DEF-1];
  int unsigned line_len  = 0;
  bit          over_flag = 1'b0;
  bit          after_cr  = 1'b0;
  logic [15:0] ovr_cnt   = '0;
  logic [15:0] ovf_cnt   = '0;
  logic [5:0]  limit_reg = MAX_LEN_RESET;

  out_t step_res[$];
  out_t due_results[$];

  int mismatch_cnt = 0;
  int idle_cycles  = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic in_t mk_in(logic [7:0] c, logic vld, logic ovr);
    in_t it;
    it.rx_byte    = c;
    it.byte_valid = vld;
    it.hw_overrun = ovr;
    return it;
  endfunction

  function automatic void add_res(kind_e k, logic [7:0] b);
    out_t r;
    r.result_kind    = k;
    r.result_byte    = b;
    r.last_of_run    = 1'b0;
    r.overrun_total  = ovr_cnt;
    r.overflow_total = ovf_cnt;
    step_res.push_back(r);
  endfunction

  // the limit register is 6 bits wide, so it never exceeds the store depth
  function automatic void assemble_step(in_t it);
    int unsigned i;
    logic [7:0]  c;
    c = it.rx_byte;
    step_res.delete();
    if (it.hw_overrun && ovr_cnt != SAT16) ovr_cnt++;
    if (!it.byte_valid) return;
    if (c == CH_CR || c == CH_LF) begin
      if (c == CH_LF && after_cr) begin
        after_cr = 1'b0;
        return;
      end
      after_cr = (c == CH_CR);
      if (over_flag && ovf_cnt != SAT16) ovf_cnt++;
      add_res(KIND_ECHO, CH_LF);
      if (over_flag) begin
        add_res(KIND_TOO_LONG, 8'h00);
      end else if (line_len != 0) begin
        for (i = 0; i < line_len; i++) add_res(KIND_LINE, line_mem[i]);
      end else begin
        add_res(KIND_EMPTY, 8'h00);
      end
      line_len  = 0;
      over_flag = 1'b0;
    end else begin
      after_cr = 1'b0;
      if (c == CH_BS || c == CH_DEL) begin
        if (line_len != 0) begin
          line_len--;
          add_res(KIND_ECHO, CH_BS);
          add_res(KIND_ECHO, CH_SPACE);
          add_res(KIND_ECHO, CH_BS);
        end
      end else if (c >= CH_SPACE && c <= CH_TILDE) begin
        add_res(KIND_ECHO, c);
        if (line_len < limit_reg) begin
          line_mem[line_len] = c;
          line_len++;
        end else begin
          over_flag = 1'b1;
        end
      end
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last_of_run = 1'b1;
  endfunction

  task automatic send_item(input in_t it, input bit use_pred);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.payload <= it;
    do @(posedge clk_i); while (!rx_ch.ready);
    assemble_step(it);
    if (use_pred) foreach (step_res[i]) due_results.push_back(step_res[i]);
  endtask

  // the limit only changes while the line editor is idle
  task automatic write_limit(input logic [5:0] v);
    cfg_t c;
    c.max_line_length = v;
    rx_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= c;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    limit_reg = v;
  endtask

  // mostly typed lines with some erasing, noise bytes and status-only reports
  task automatic send_random_lines(input int quota);
    int         sent;
    int         len;
    int         k;
    int         pick;
    logic [7:0] c;
    logic       vld;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 10);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        vld  = 1'b1;
        if (pick < 8) begin
          c = pick[0] ? CH_BS : CH_DEL;
        end else if (pick < 11) begin
          c = 8'($urandom_range(128, 255));
        end else if (pick < 13) begin
          c = 8'($urandom_range(0, 31));
        end else if (pick < 16) begin
          c   = 8'($urandom_range(0, 255));
          vld = 1'b0;
        end else begin
          c = 8'($urandom_range(32, 126));
        end
        send_item(mk_in(c, vld, $urandom_range(15) == 0), 1'b1);
        sent++;
      end
      pick = $urandom_range(9);
      if (pick < 4) begin
        send_item(mk_in(CH_CR, 1'b1, $urandom_range(15) == 0), 1'b1);
        sent++;
      end else if (pick < 7) begin
        send_item(mk_in(CH_LF, 1'b1, $urandom_range(15) == 0), 1'b1);
        sent++;
      end else begin
        send_item(mk_in(CH_CR, 1'b1, $urandom_range(15) == 0), 1'b1);
        send_item(mk_in(CH_LF, 1'b1, $urandom_range(15) == 0), 1'b1);
        sent += 2;
      end
    end
  endtask

  function automatic void note_bad(string field, logic [15:0] want, logic [15:0] got);
    mismatch_cnt++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  always @(posedge clk_i) begin : result_check
    out_t want;
    out_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (due_results.size() == 0) begin
        mismatch_cnt++;
        $error("result with nothing due: kind %0d byte %0h", got.result_kind, got.result_byte);
      end else begin
        want = due_results.pop_front();
        if (want.result_kind !== got.result_kind)
          note_bad("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        if (want.result_byte !== got.result_byte)
          note_bad("result_byte", 16'(want.result_byte), 16'(got.result_byte));
        if (want.last_of_run !== got.last_of_run)
          note_bad("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
        if (want.overrun_total !== got.overrun_total)
          note_bad("overrun_total", want.overrun_total, got.overrun_total);
        if (want.overflow_total !== got.overflow_total)
          note_bad("overflow_total", want.overflow_total, got.overflow_total);
      end
    end
  end

  // cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((rx_ch.valid && rx_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                 (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    step_row_t  row;
    out_t       res;
    int         j;
    int         blk;
    logic [5:0] blk_limit [6];

    rx_ch.valid    = 1'b0;
    rx_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    res_ch.ready   = 1'b0;
    snd_idle_pct   = 33;
    rcv_idle_pct   = 78;
    blk_limit = '{6'd3, 6'd63, 6'd1, 6'($urandom_range(2, 62)), 6'd63, 6'd7};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      row = dir_tab[r];
      if (row.wr_cfg) begin
        write_limit(row.data[5:0]);
      end else begin
        send_item(mk_in(row.data, row.vld, row.ovr), !row.typed);
        if (row.typed) begin
          for (j = 0; j < row.n; j++) begin
            res.result_kind    = (j == 0) ? row.k0 : (j == 1) ? row.k1 : row.k2;
            res.result_byte    = (j == 0) ? row.b0 : (j == 1) ? row.b1 : row.b2;
            res.last_of_run    = (j == row.n - 1);
            res.overrun_total  = row.ovr_t;
            res.overflow_total = row.ovf_t;
            due_results.push_back(res);
          end
        end
      end
    end

    for (blk = 0; blk < 6; blk++) begin
      if (blk == 2) begin
        snd_idle_pct = 78;
        rcv_idle_pct = 33;
      end
      if (blk == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_limit(blk_limit[blk]);
      send_random_lines(BLOCK_ITEMS);
    end

    rx_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
